// ===== hw/rtl/tcpsm_pkg.sv =====
// ============================================================================
// tcpsm_pkg
// Types and codes shared by the TCP connection state machine.
// ============================================================================
package tcpsm_pkg;

    // Flag bit positions in the 16-bit TCP flag word
    localparam int unsigned FLAG_W   = 16;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned FIN_BIT  = 8;
    localparam int unsigned SYN_BIT  = 9;
    localparam int unsigned ACK_BIT  = 12;

    localparam logic [FLAG_W-1:0] F_SYN = FLAG_W'(1) << SYN_BIT;
    localparam logic [FLAG_W-1:0] F_FIN = FLAG_W'(1) << FIN_BIT;
    localparam logic [FLAG_W-1:0] F_ACK = FLAG_W'(1) << ACK_BIT;

    // Stream widths
    localparam int unsigned S_TDATA_W = 88;   // 84 bits of fields, padded to bytes
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned M_TUSER_W = 3;

    // Input kind
    typedef enum logic {
        KIND_SEGMENT = 1'b0,
        KIND_SW_WRITE = 1'b1
    } kind_t;

    // Connection state
    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_SENT    = 4'd2,
        ST_SYN_RCVD    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_FIN_WAIT_1  = 4'd5,
        ST_FIN_WAIT_2  = 4'd6,
        ST_CLOSING     = 4'd7,
        ST_TIME_WAIT   = 4'd8,
        ST_LAST_ACK    = 4'd9
    } conn_state_t;

    // Result action
    typedef enum logic [2:0] {
        ACT_SEND    = 3'd0,
        ACT_DELIVER = 3'd1,
        ACT_CONN    = 3'd2,
        ACT_SYNACC  = 3'd3,
        ACT_ACKACC  = 3'd4
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [FLAG_W-1:0] flags;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
    } result_t;

    localparam result_t RESULT_NONE = '{action: ACT_SEND, flags: '0, seq: '0, ack: '0};

endpackage

// ===== hw/rtl/tcp_connection_state_machine.sv =====
// ============================================================================
// tcp_connection_state_machine
// Connection state tracker for one TCP connection: classifies received
// segments, steps the handshake/teardown states and emits replies and
// notifications.
// ============================================================================
//
//  channel   dir  tdata (low bit up)                              tuser    tlast
//  s_axis    in   tcp_flags[15:0] seq_num[47:16] ack_num[79:48]   kind     -
//                 new_state[83:80], zero pad [87:84]
//  m_axis    out  out_flags[15:0] out_seq[47:16] out_ack[79:48]   action   last
//
//  An input beat is decoded in the cycle it is accepted; its results (0..2)
//  land in a two-entry result buffer and the connection state updates at the
//  same edge. Results leave through the single output port, one per cycle
//  while m_axis_tready is high. The input is taken whenever the buffer is
//  empty or its last entry is being taken in that cycle, so beats with at
//  most one result each flow back to back while m_axis_tready is high.
//  Reset (rst_n, async, active low) empties the buffer and sets CLOSED.
//  A stall on m_axis holds the buffer; s_axis_tready is low while the buffer
//  holds two results, or one that is not being taken.
//
module tcp_connection_state_machine
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tcp_flags, seq_num, ack_num, new_state, pad
    input  logic [tcpsm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic [tcpsm_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_flags, out_seq, out_ack
    output logic [tcpsm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // action
    output logic [tcpsm_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast
);
    import tcpsm_pkg::*;

    // ---- input unpacking ----
    kind_t             in_kind;
    logic [FLAG_W-1:0] in_flags;
    logic [SEQ_W-1:0]  in_seq;
    logic [SEQ_W-1:0]  in_ack;
    logic [3:0]        in_new_state;

    assign in_kind      = kind_t'(s_axis_tuser[0]);
    assign in_flags     = s_axis_tdata[15:0];
    assign in_seq       = s_axis_tdata[47:16];
    assign in_ack       = s_axis_tdata[79:48];
    assign in_new_state = s_axis_tdata[83:80];

    logic syn_f, fin_f, ack_f;
    assign syn_f = in_flags[SYN_BIT];
    assign fin_f = in_flags[FIN_BIT];
    assign ack_f = in_flags[ACK_BIT];

    logic [SEQ_W-1:0] rep_ack;
    assign rep_ack = in_seq + SEQ_W'(1);   // wraps mod 2^32

    // ---- state and result buffer ----
    conn_state_t state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;        // results held, 0..2
    result_t     slot0_reg, slot1_reg;     // slot0 is the one on the port

    logic in_acc, out_take;
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        if (in_acc)
        begin
            if (in_kind == KIND_SW_WRITE)
            begin
                // codes above LAST_ACK are dropped
                if (in_new_state <= 4'(ST_LAST_ACK))
                    state_next = conn_state_t'(in_new_state);
            end
            else if (syn_f && ack_f)
            begin
                if (state_reg == ST_SYN_SENT)
                    state_next = ST_ESTABLISHED;
            end
            else if (syn_f)
            begin
                if (state_reg == ST_LISTEN || state_reg == ST_SYN_SENT)
                    state_next = ST_SYN_RCVD;
            end
            else if (fin_f)
            begin
                case (state_reg)
                    ST_ESTABLISHED: state_next = ST_LAST_ACK;
                    ST_FIN_WAIT_1:  state_next = ST_CLOSING;
                    ST_FIN_WAIT_2:  state_next = ST_TIME_WAIT;
                    default:        state_next = state_reg;
                endcase
            end
            else if (ack_f)
            begin
                case (state_reg)
                    ST_SYN_RCVD:   state_next = ST_ESTABLISHED;
                    ST_FIN_WAIT_1: state_next = ST_FIN_WAIT_2;
                    ST_CLOSING:    state_next = ST_TIME_WAIT;
                    ST_LAST_ACK:   state_next = ST_CLOSED;
                    default:       state_next = state_reg;
                endcase
            end
        end
    end

    // ---- results of the beat on the input ----
    logic [1:0] n_res;
    result_t    res0, res1;
    result_t    send_ack, deliver;

    assign send_ack = '{action: ACT_SEND, flags: F_ACK, seq: in_ack, ack: rep_ack};
    assign deliver  = '{action: ACT_DELIVER, flags: in_flags, seq: in_seq, ack: in_ack};

    always_comb
    begin
        n_res = 2'd0;
        res0  = RESULT_NONE;
        res1  = RESULT_NONE;
        if (in_kind == KIND_SEGMENT)
        begin
            if (syn_f && ack_f)
            begin
                if (state_reg == ST_SYN_SENT)
                begin
                    n_res = 2'd2;
                    res0  = send_ack;
                    res1  = '{action: ACT_CONN, flags: '0, seq: '0, ack: '0};
                end
            end
            else if (syn_f)
            begin
                if (state_reg == ST_LISTEN)
                begin
                    n_res = 2'd2;
                    res0  = '{action: ACT_SEND, flags: F_SYN | F_ACK,
                              seq: in_ack, ack: rep_ack};
                    res1  = '{action: ACT_SYNACC, flags: '0, seq: '0, ack: '0};
                end
                else if (state_reg == ST_SYN_SENT)
                begin
                    n_res = 2'd1;
                    res0  = send_ack;
                end
            end
            else if (fin_f)
            begin
                case (state_reg)
                    ST_ESTABLISHED:
                    begin
                        n_res = 2'd2;
                        res0  = send_ack;
                        res1  = '{action: ACT_SEND, flags: F_FIN,
                                  seq: in_ack, ack: rep_ack};
                    end
                    ST_FIN_WAIT_1, ST_FIN_WAIT_2:
                    begin
                        n_res = 2'd1;
                        res0  = send_ack;
                    end
                    default: n_res = 2'd0;
                endcase
            end
            else if (ack_f)
            begin
                case (state_reg)
                    ST_SYN_RCVD:
                    begin
                        n_res = 2'd1;
                        res0  = '{action: ACT_ACKACC, flags: '0, seq: '0, ack: '0};
                    end
                    ST_ESTABLISHED:
                    begin
                        n_res = 2'd1;
                        res0  = deliver;
                    end
                    default: n_res = 2'd0;
                endcase
            end
            else
            begin
                // no SYN, FIN or ACK: straight to the data path
                n_res = 2'd1;
                res0  = deliver;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc)
            cnt_next = n_res;
        else if (out_take)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLOSED;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_take)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    // ---- output port ----
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tlast  = (cnt_reg == 2'd1);
    assign m_axis_tuser  = slot0_reg.action;
    assign m_axis_tdata  = {slot0_reg.ack, slot0_reg.seq, slot0_reg.flags};

    // ---- checks ----
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_state_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready) |=> $stable(state_reg))
        else $error("connection state moved without an input beat");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> m_axis_tvalid && !m_axis_tlast)
        else $error("first of two results marked last");

    a_notify_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (slot0_reg.action == ACT_CONN || slot0_reg.action == ACT_SYNACC
            || slot0_reg.action == ACT_ACKACC) |-> m_axis_tdata == '0)
        else $error("notification carries data");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// TCP connection state machine testbench
// Drives segment and state-write beats into the connection tracker and holds
// a cycle-free copy of its state machine to predict every reply and
// notification. Each result beat is checked field by field against the
// oldest prediction. Both sides idle and stall at random, apart from a quiet
// tail at the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpsm_pkg::*;

    // Number of random beats, and the beat count after which the
    // random idling stops for the tail of the run.
    localparam int RANDOM_BEATS = 1250;
    localparam int QUIET_AFTER  = 1050;
    // Cycles with no beat accepted on either side before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [FLAG_W-1:0] CLASS_BITS = F_SYN | F_FIN | F_ACK;

    // One reply or notification as it leaves the master side
    typedef struct {
        action_t           act;
        logic [FLAG_W-1:0] flags;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        logic              last;
    } reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;

    // Predicted connection state and the replies still owed by the block
    conn_state_t tracked_state;
    reply_t      replies_due[$];

    int  errors;
    int  effective_beats;
    int  segments_sent;
    int  writes_sent;
    int  results_checked;
    int  action_seen[5];
    int  idle_cycles;
    bit  quiet_tail;
    int  tx_gap_odds;
    int  rx_stall_odds;

    tcp_connection_state_machine DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: steps the tracked state for one accepted beat and queues the
    // replies it owes. Returns 1 on a kept write, a state change or a reply.
    // ------------------------------------------------------------------------
    function automatic bit predict_replies(kind_t k, logic [FLAG_W-1:0] fl,
                                           logic [SEQ_W-1:0] sq,
                                           logic [SEQ_W-1:0] ak,
                                           logic [3:0] ns);
        reply_t           batch[$];
        logic [SEQ_W-1:0] rep_ack;
        bit               syn;
        bit               fin;
        bit               ackf;
        conn_state_t      was;
        rep_ack = sq + 1;
        syn     = (fl & F_SYN) != 0;
        fin     = (fl & F_FIN) != 0;
        ackf    = (fl & F_ACK) != 0;
        was     = tracked_state;

        if (k == KIND_SW_WRITE)
        begin
            // socket call: codes beyond LAST_ACK are dropped
            if (ns <= ST_LAST_ACK)
            begin
                tracked_state = conn_state_t'(ns);
                return 1'b1;
            end
            return 1'b0;
        end

        // class priority: SYN+ACK, SYN, FIN, ACK, none
        if (syn && ackf)
        begin
            if (was == ST_SYN_SENT)
            begin
                batch.push_back('{ACT_SEND, F_ACK, ak, rep_ack, 1'b0});
                batch.push_back('{ACT_CONN, '0, '0, '0, 1'b0});
                tracked_state = ST_ESTABLISHED;
            end
        end
        else if (syn)
        begin
            if (was == ST_LISTEN)
            begin
                batch.push_back('{ACT_SEND, F_SYN | F_ACK, ak, rep_ack, 1'b0});
                batch.push_back('{ACT_SYNACC, '0, '0, '0, 1'b0});
                tracked_state = ST_SYN_RCVD;
            end
            else if (was == ST_SYN_SENT)
            begin
                // simultaneous open
                batch.push_back('{ACT_SEND, F_ACK, ak, rep_ack, 1'b0});
                tracked_state = ST_SYN_RCVD;
            end
        end
        else if (fin)
        begin
            if (was == ST_ESTABLISHED)
            begin
                batch.push_back('{ACT_SEND, F_ACK, ak, rep_ack, 1'b0});
                batch.push_back('{ACT_SEND, F_FIN, ak, rep_ack, 1'b0});
                tracked_state = ST_LAST_ACK;
            end
            else if (was == ST_FIN_WAIT_1)
            begin
                batch.push_back('{ACT_SEND, F_ACK, ak, rep_ack, 1'b0});
                tracked_state = ST_CLOSING;
            end
            else if (was == ST_FIN_WAIT_2)
            begin
                batch.push_back('{ACT_SEND, F_ACK, ak, rep_ack, 1'b0});
                tracked_state = ST_TIME_WAIT;
            end
        end
        else if (ackf)
        begin
            case (was)
                ST_SYN_RCVD:
                begin
                    batch.push_back('{ACT_ACKACC, '0, '0, '0, 1'b0});
                    tracked_state = ST_ESTABLISHED;
                end
                ST_FIN_WAIT_1:  tracked_state = ST_FIN_WAIT_2;
                ST_CLOSING:     tracked_state = ST_TIME_WAIT;
                ST_LAST_ACK:    tracked_state = ST_CLOSED;
                ST_ESTABLISHED: batch.push_back('{ACT_DELIVER, fl, sq, ak, 1'b0});
                default:        ;
            endcase
        end
        else
        begin
            // no class bit at all: straight to the data path in any state
            batch.push_back('{ACT_DELIVER, fl, sq, ak, 1'b0});
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            replies_due.push_back(batch[i]);
        return (batch.size() > 0) || (tracked_state != was);
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called and returning at a falling edge; valid is left high so
    // that the next beat can follow with no gap.
    // ------------------------------------------------------------------------
    task automatic send_beat(kind_t k, logic [FLAG_W-1:0] fl,
                             logic [SEQ_W-1:0] sq, logic [SEQ_W-1:0] ak,
                             logic [3:0] ns);
        int gap;
        gap = 0;
        if (!quiet_tail && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
            gap = $urandom_range(1, 19);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {4'b0, ns, ak, sq, fl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_replies(k, fl, sq, ak, ns))
            effective_beats++;
        if (k == KIND_SW_WRITE)
            writes_sent++;
        else
            segments_sent++;
        @(negedge clk);
    endtask

    // Sender holds off until the block owes nothing more
    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [SEQ_W-1:0] pick_seq();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Flag bits that play no part in classification
    function automatic logic [FLAG_W-1:0] spare_flags();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return FLAG_W'($urandom) & ~CLASS_BITS;
    endfunction

    task automatic send_segment(logic [FLAG_W-1:0] cls);
        send_beat(KIND_SEGMENT, cls | spare_flags(), pick_seq(), pick_seq(),
                  4'($urandom_range(0, 15)));
    endtask

    task automatic socket_write(logic [3:0] ns);
        send_beat(KIND_SW_WRITE, FLAG_W'($urandom), $urandom, $urandom, ns);
    endtask

    // Fully random beat of either kind
    task automatic send_noise();
        send_beat(kind_t'($urandom_range(0, 1)), FLAG_W'($urandom), pick_seq(),
                  pick_seq(), 4'($urandom_range(0, 15)));
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0)
            send_noise();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stalls in bursts; the stall rate changes now and then,
    // including long stretches with no stalls at all.
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        rx_stall_odds = 4;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                rx_stall_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 8);
            if (!quiet_tail && rx_stall_odds != 0 &&
                $urandom_range(1, rx_stall_odds) == 1)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result beat against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic field_mismatch(string name, logic [SEQ_W-1:0] want,
                                  logic [SEQ_W-1:0] seen);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
        errors++;
    endtask

    always @(posedge clk)
    begin : result_check
        reply_t want;
        reply_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.act   = action_t'(m_axis_tuser);
            seen.flags = m_axis_tdata[15:0];
            seen.seq   = m_axis_tdata[47:16];
            seen.ack   = m_axis_tdata[79:48];
            seen.last  = m_axis_tlast;
            if (replies_due.size() == 0)
            begin
                // got: action/flags/seq/ack/last
                $display("%0t: unexpected result, expected none, got %0d/0x%0h/0x%0h/0x%0h/%0b",
                         $time, seen.act, seen.flags, seen.seq, seen.ack, seen.last);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (seen.act !== want.act)
                    field_mismatch("action", want.act, seen.act);
                if (seen.flags !== want.flags)
                    field_mismatch("out_flags", want.flags, seen.flags);
                if (seen.seq !== want.seq)
                    field_mismatch("out_seq", want.seq, seen.seq);
                if (seen.ack !== want.ack)
                    field_mismatch("out_ack", want.ack, seen.ack);
                if (seen.last !== want.last)
                    field_mismatch("last", want.last, seen.last);
                results_checked++;
                if (want.act <= ACT_ACKACC)
                    action_seen[want.act]++;
            end
        end
    end

    // Watchdog: consecutive cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // listen, SYN with seq wrapping, ACK, data, remote close
    task automatic test_passive_open();
        socket_write(ST_LISTEN);
        send_beat(KIND_SEGMENT, F_SYN, 32'hFFFF_FFFF, 32'h0, 4'h0);
        send_beat(KIND_SEGMENT, F_ACK, 32'h0000_0001, 32'h1234_5678, 4'hF);
        send_beat(KIND_SEGMENT, F_ACK | 16'h0018, 32'h8000_0000, 32'h7FFF_FFFF, 4'h0);
        send_beat(KIND_SEGMENT, F_FIN | F_ACK, 32'h0000_0000, 32'hFFFF_FFFF, 4'h0);
        send_beat(KIND_SEGMENT, F_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    endtask

    // connect, SYN+ACK with every flag bit set, local close through CLOSING
    task automatic test_active_open();
        socket_write(ST_SYN_SENT);
        send_beat(KIND_SEGMENT, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 4'h0);
        socket_write(ST_FIN_WAIT_1);
        send_beat(KIND_SEGMENT, F_FIN, 32'hDEAD_BEEF, 32'h0000_0000, 4'h0);
        send_beat(KIND_SEGMENT, F_ACK, 32'h0, 32'h0, 4'h0);
    endtask

    // both ends open at once, then close through FIN_WAIT_2
    task automatic test_simultaneous_open();
        socket_write(ST_SYN_SENT);
        send_beat(KIND_SEGMENT, F_SYN | 16'h00FF, 32'h1000_0000, 32'h2000_0000, 4'h0);
        socket_write(ST_FIN_WAIT_1);
        send_beat(KIND_SEGMENT, F_ACK, 32'h0, 32'h0, 4'h0);
        send_beat(KIND_SEGMENT, F_FIN | 16'hE000, 32'hFFFF_FFFE, 32'h1, 4'h0);
    endtask

    // flag word with no class bit, classes not handled, bad state codes
    task automatic test_special_cases();
        send_beat(KIND_SEGMENT, 16'hFFFF & ~CLASS_BITS, 32'hFFFF_FFFF, 32'h0, 4'hF);
        send_beat(KIND_SEGMENT, F_SYN, 32'h1, 32'h2, 4'h0);
        socket_write(4'd15);
        socket_write(4'd10);
        send_beat(KIND_SEGMENT, F_SYN | F_ACK, 32'h1, 32'h2, 4'h0);
        socket_write(ST_CLOSED);
        send_beat(KIND_SEGMENT, F_FIN, 32'h3, 32'h4, 4'h0);
        send_beat(KIND_SEGMENT, F_ACK, 32'h5, 32'h6, 4'h0);
    endtask

    // sender holds back until every owed result has drained
    task automatic test_drain_pause();
        socket_write(ST_LISTEN);
        send_segment(F_SYN);
        wait_for_replies();
        send_segment(F_ACK);
        send_segment(F_FIN);
        wait_for_replies();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly whole connections with random numbers and spare
    // flag bits, mixed with stray beats and broken sessions.
    // ------------------------------------------------------------------------
    task automatic run_connection();
        case ($urandom_range(0, 3))
            0:
            begin
                socket_write(ST_LISTEN);
                maybe_noise();
                send_segment(F_SYN);
                maybe_noise();
                send_segment(F_ACK);
            end
            1:
            begin
                socket_write(ST_SYN_SENT);
                maybe_noise();
                send_segment(F_SYN | F_ACK);
            end
            2:
            begin
                socket_write(ST_SYN_SENT);
                send_segment(F_SYN);
                maybe_noise();
                send_segment(F_ACK);
            end
            default:
                // broken session: start from any state
                socket_write(4'($urandom_range(0, 9)));
        endcase

        repeat ($urandom_range(0, 6))
        begin
            send_segment($urandom_range(0, 2) != 0 ? F_ACK : '0);
            maybe_noise();
        end

        case ($urandom_range(0, 2))
            0:
            begin
                send_segment($urandom_range(0, 1) ? (F_FIN | F_ACK) : F_FIN);
                send_segment(F_ACK);
            end
            1:
            begin
                socket_write(ST_FIN_WAIT_1);
                send_segment(F_FIN);
                send_segment(F_ACK);
            end
            default:
            begin
                socket_write(ST_FIN_WAIT_1);
                send_segment(F_ACK);
                maybe_noise();
                send_segment(F_FIN);
            end
        endcase
        if ($urandom_range(0, 1) == 0)
            socket_write(ST_CLOSED);
    endtask

    task automatic test_random_traffic();
        int start;
        start = segments_sent + writes_sent;
        while (segments_sent + writes_sent - start < RANDOM_BEATS)
        begin
            if (segments_sent + writes_sent - start > QUIET_AFTER)
                quiet_tail = 1'b1;
            // per-session sender idling: sometimes none for a while
            tx_gap_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 10);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_noise();
            else
                run_connection();
            if (!quiet_tail && $urandom_range(0, 24) == 0)
                wait_for_replies();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        tracked_state   = ST_CLOSED;
        errors          = 0;
        effective_beats = 0;
        segments_sent   = 0;
        writes_sent     = 0;
        results_checked = 0;
        idle_cycles     = 0;
        quiet_tail      = 1'b0;
        tx_gap_odds     = 4;
        foreach (action_seen[i])
            action_seen[i] = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_passive_open();
        test_active_open();
        test_simultaneous_open();
        test_special_cases();
        test_drain_pause();
        test_random_traffic();

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d segments, %0d socket writes (%0d acted on); %0d results checked",
                 segments_sent, writes_sent, effective_beats, results_checked);
        $display("By action: send %0d, deliver %0d, conn %0d, syn acc %0d, ack acc %0d",
                 action_seen[ACT_SEND], action_seen[ACT_DELIVER], action_seen[ACT_CONN],
                 action_seen[ACT_SYNACC], action_seen[ACT_ACKACC]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
